### src/trmp_pkg.sv
// Shared types, fixed-point constants and the arctangent table for the motion predictor.
package trmp_pkg;

    // Angle constants in Q4.28
    localparam longint PI_Q28      = 843314857;
    localparam longint TWO_PI_Q28  = 1686629713;
    localparam longint HALF_PI_Q28 = 421657428;

    // Rotation gain in Q2.30
    localparam longint CORDIC_GAIN_Q30 = 652032874;

    // Reset values of the configuration registers
    localparam logic [30:0] TURN_THRESHOLD_RST     = 31'd26843546;
    localparam logic [30:0] HEADING_NOISE_BAND_RST = 31'd53687091;
    localparam logic [31:0] SPEED_MIN_RST          = 32'hFFFF_0000;
    localparam logic [31:0] SPEED_MAX_RST          = 32'd1310720;
    localparam logic [30:0] EXTENT_MAX_RST         = 31'd1966080;
    localparam logic [30:0] CURVATURE_MAX_RST      = 31'd64424509;

    // Datapath widths
    localparam int MOD_W     = 48;          // angle word fed to the modulo unit
    localparam int MOD_STEPS = 17;          // compare/subtract steps of the modulo unit
    localparam int MOD_LAT   = MOD_STEPS + 2;
    localparam int ANG_W     = 31;          // reduced angle in [0, 2pi)
    localparam int CORDIC_W  = 34;          // rotation datapath width
    localparam int DEN_W     = 32;          // divisor magnitude width
    localparam int DIV_NW    = CORDIC_W + 17;  // dividend magnitude width
    localparam int DIV_LAT   = DIV_NW + 2;
    localparam int CHORD_W   = 48;          // chord word, wide enough for divider widths up to 48 bits

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TURN_THRESHOLD     = 3'd0,
        CFG_HEADING_NOISE_BAND = 3'd1,
        CFG_SPEED_MIN          = 3'd2,
        CFG_SPEED_MAX          = 3'd3,
        CFG_EXTENT_MAX         = 3'd4,
        CFG_CURVATURE_MAX      = 3'd5
    } cfg_idx_t;

    // One input item
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] speed;
        logic signed [31:0] extent;
        logic signed [31:0] curvature;
        logic signed [31:0] noise_x;
        logic signed [31:0] noise_y;
        logic signed [31:0] noise_heading;
        logic signed [31:0] noise_speed;
        logic signed [31:0] noise_extent;
        logic signed [31:0] noise_curvature;
    } item_t;

    // Per-item fields that ride beside the trig and divide units
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] sp;
        logic signed [31:0] cv;
        logic               straight;
        logic               inrange;
        logic        [30:0] h_in;
        logic signed [31:0] s;
        logic        [30:0] e;
        logic signed [31:0] c;
    } side_t;

    // Fields that travel through the displacement multiply stages
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic        [30:0] heading;
        logic signed [31:0] s;
        logic        [30:0] e;
        logic signed [31:0] c;
    } tail_t;

    // atan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            24: v = 32'd64;
            25: v = 32'd32;
            26: v = 32'd16;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### src/turn_rate_motion_predict_unit.sv
// Top level of the constant-turn-rate particle motion predictor.
// Each accepted particle gives one predicted pose; one particle enters per cycle while the input
// is not stalled, and results leave in order. The pipeline has three input stages (register,
// speed*curvature multiply and noise fold, turn and clamps), the sine path (19-step modulo 2pi,
// fold, CORDIC_STAGES rotations, sign), the 53-stage bit-per-stage chord divider, and four
// stages for chord select, the two split multiplies of the displacement and the final saturating
// sums. The heading cosine/sine and heading wrap run beside the sine path. All stages advance
// together; holding out_stall while a result is valid freezes the pipeline and stalls the input.
// Configuration registers are read live and must only change while no particle is in flight.
module turn_rate_motion_predict_unit
    import trmp_pkg::*;
#(
    parameter int CORDIC_STAGES = 24,
    parameter int DIVIDER_BITS  = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] heading,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] extent,
    input  logic signed [31:0] curvature,
    input  logic signed [31:0] noise_x,
    input  logic signed [31:0] noise_y,
    input  logic signed [31:0] noise_heading,
    input  logic signed [31:0] noise_speed,
    input  logic signed [31:0] noise_extent,
    input  logic signed [31:0] noise_curvature,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] next_x,
    output logic signed [31:0] next_y,
    output logic signed [30:0] next_heading,
    output logic signed [31:0] next_speed,
    output logic        [30:0] next_extent,
    output logic signed [31:0] next_curvature
);

    localparam int SC_LAT = MOD_LAT + CORDIC_STAGES + 2;
    localparam int JOIN_D = SC_LAT + DIV_LAT;
    localparam int HM_D   = JOIN_D - MOD_LAT;

    // ------------------------------------------------------------------
    // Configuration registers
    logic        [30:0] turn_threshold_reg;
    logic        [30:0] heading_noise_band_reg;
    logic signed [31:0] speed_min_reg;
    logic signed [31:0] speed_max_reg;
    logic        [30:0] extent_max_reg;
    logic        [30:0] curvature_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_threshold_reg     <= TURN_THRESHOLD_RST;
            heading_noise_band_reg <= HEADING_NOISE_BAND_RST;
            speed_min_reg          <= SPEED_MIN_RST;
            speed_max_reg          <= SPEED_MAX_RST;
            extent_max_reg         <= EXTENT_MAX_RST;
            curvature_max_reg      <= CURVATURE_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TURN_THRESHOLD:     turn_threshold_reg     <= cfg_data[30:0];
                CFG_HEADING_NOISE_BAND: heading_noise_band_reg <= cfg_data[30:0];
                CFG_SPEED_MIN:          speed_min_reg          <= cfg_data;
                CFG_SPEED_MAX:          speed_max_reg          <= cfg_data;
                CFG_EXTENT_MAX:         extent_max_reg         <= cfg_data[30:0];
                CFG_CURVATURE_MAX:      curvature_max_reg      <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Valid bits
    logic v1_reg, v2_reg, v3_reg, vj1_reg, vj2_reg, vj3_reg, out_valid_reg;
    logic vd_reg [JOIN_D];

    // ------------------------------------------------------------------
    // Pipeline enable: everything holds while a finished result is stalled
    logic en;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vj1_reg       <= 1'b0;
            vj2_reg       <= 1'b0;
            vj3_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < JOIN_D; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int k = 1; k < JOIN_D; k++)
                vd_reg[k] <= vd_reg[k-1];
            vj1_reg       <= vd_reg[JOIN_D-1];
            vj2_reg       <= vj1_reg;
            vj3_reg       <= vj2_reg;
            out_valid_reg <= vj3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the transfer
    item_t in1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in1_reg.pos_x           <= pos_x;
            in1_reg.pos_y           <= pos_y;
            in1_reg.heading         <= heading;
            in1_reg.speed           <= speed;
            in1_reg.extent          <= extent;
            in1_reg.curvature       <= curvature;
            in1_reg.noise_x         <= noise_x;
            in1_reg.noise_y         <= noise_y;
            in1_reg.noise_heading   <= noise_heading;
            in1_reg.noise_speed     <= noise_speed;
            in1_reg.noise_extent    <= noise_extent;
            in1_reg.noise_curvature <= noise_curvature;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: speed * curvature, heading noise fold
    item_t              in2_reg;
    logic signed [63:0] prod_reg;
    logic signed [33:0] nhf_reg;
    logic signed [33:0] nhf_next;

    always_comb
    begin
        logic signed [33:0] nh;
        logic signed [33:0] b1;
        logic signed [33:0] b2;
        nh = 34'(in1_reg.noise_heading);
        b1 = $signed({3'b000, heading_noise_band_reg});
        b2 = b1 <<< 1;
        priority if (nh > b2)
            nhf_next = b1 - 34'(PI_Q28);
        else if (nh > b1)
            nhf_next = nh - b1 - 34'(PI_Q28);
        else if (nh > -b1)
            nhf_next = nh;
        else if (nh > -b2)
            nhf_next = nh + b1 + 34'(PI_Q28);
        else
            nhf_next = 34'(PI_Q28) - b1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in2_reg  <= in1_reg;
            prod_reg <= $signed(in1_reg.speed) * $signed(in1_reg.curvature);
            nhf_reg  <= nhf_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: turn, trig angles, heading sum, clamps
    logic signed [45:0]      turn;
    logic signed [44:0]      half;
    logic        [45:0]      aturn;
    logic signed [MOD_W-1:0] ang2_next;
    logic signed [MOD_W-1:0] hsum_next;
    logic signed [32:0]      s33, e33, c33, cm33;
    side_t                   side_next;

    assign turn  = prod_reg[63:18];
    assign half  = prod_reg[63:19];
    assign aturn = turn[45] ? 46'(-turn) : 46'(turn);

    assign ang2_next = MOD_W'(in2_reg.heading) + MOD_W'(half);
    assign hsum_next = MOD_W'(in2_reg.heading) + MOD_W'(turn) + MOD_W'(nhf_reg);

    assign s33  = 33'(in2_reg.speed) + 33'(in2_reg.noise_speed);
    assign e33  = 33'(in2_reg.extent) + 33'(in2_reg.noise_extent);
    assign c33  = 33'(in2_reg.curvature) + 33'(in2_reg.noise_curvature);
    assign cm33 = $signed({2'b00, curvature_max_reg});

    always_comb
    begin
        side_next.px       = in2_reg.pos_x;
        side_next.py       = in2_reg.pos_y;
        side_next.nx       = in2_reg.noise_x;
        side_next.ny       = in2_reg.noise_y;
        side_next.sp       = in2_reg.speed;
        side_next.cv       = in2_reg.curvature;
        side_next.straight = (aturn < {15'd0, turn_threshold_reg}) || (in2_reg.curvature == '0);
        side_next.inrange  = (hsum_next >= -MOD_W'(PI_Q28)) && (hsum_next <= MOD_W'(PI_Q28));
        side_next.h_in     = hsum_next[30:0];

        // speed: lower bound tested first
        priority if (s33 < 33'(speed_min_reg))
            side_next.s = speed_min_reg;
        else if (s33 > 33'(speed_max_reg))
            side_next.s = speed_max_reg;
        else
            side_next.s = s33[31:0];

        // extent: zero floor first
        priority if (e33 < 33'sd0)
            side_next.e = '0;
        else if (e33 > $signed({2'b00, extent_max_reg}))
            side_next.e = extent_max_reg;
        else
            side_next.e = e33[30:0];

        // curvature: upper bound tested first
        priority if (c33 > cm33)
            side_next.c = cm33[31:0];
        else if (c33 < -cm33)
            side_next.c = 32'(-cm33);
        else
            side_next.c = c33[31:0];
    end

    side_t                   side_reg;
    logic signed [MOD_W-1:0] half_reg;
    logic signed [MOD_W-1:0] ang2_reg;
    logic signed [MOD_W-1:0] hsum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            half_reg <= MOD_W'(half);
            ang2_reg <= ang2_next;
            hsum_reg <= hsum_next;
        end
    end

    // ------------------------------------------------------------------
    // Trig, divide and heading wrap units
    logic signed [CORDIC_W-1:0]     cos_half, sin_half, cos_head, sin_head;
    logic signed [DIVIDER_BITS-1:0] quo;
    logic        [ANG_W-1:0]        hmod;
    side_t                          side_dly [JOIN_D];

    trmp_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_half
    (
        .clk  (clk),
        .en   (en),
        .ang  (half_reg),
        .cosv (cos_half),
        .sinv (sin_half)
    );

    trmp_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_head
    (
        .clk  (clk),
        .en   (en),
        .ang  (ang2_reg),
        .cosv (cos_head),
        .sinv (sin_head)
    );

    trmp_div #(.DIVIDER_BITS(DIVIDER_BITS)) u_div
    (
        .clk     (clk),
        .en      (en),
        .num_sin (sin_half),
        .den     (side_dly[SC_LAT-1].cv),
        .quo     (quo)
    );

    trmp_mod2pi u_hmod
    (
        .clk (clk),
        .en  (en),
        .ang (hsum_reg),
        .res (hmod)
    );

    // Delay lines that line everything up with the divider output
    logic signed [CORDIC_W-1:0] co_dly [DIV_LAT];
    logic signed [CORDIC_W-1:0] si_dly [DIV_LAT];
    logic        [ANG_W-1:0]    hm_dly [HM_D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly[0] <= side_reg;
            for (int k = 1; k < JOIN_D; k++)
                side_dly[k] <= side_dly[k-1];
            co_dly[0] <= cos_head;
            si_dly[0] <= sin_head;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                co_dly[k] <= co_dly[k-1];
                si_dly[k] <= si_dly[k-1];
            end
            hm_dly[0] <= hmod;
            for (int k = 1; k < HM_D; k++)
                hm_dly[k] <= hm_dly[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Join: chord select and heading wrap
    side_t                     sj;
    logic        [ANG_W-1:0]   hm_j;
    logic signed [31:0]        hwrap;
    logic signed [CHORD_W-1:0] chord_next;
    tail_t                     tail_next;

    assign sj   = side_dly[JOIN_D-1];
    assign hm_j = hm_dly[HM_D-1];

    assign hwrap = (hm_j > ANG_W'(PI_Q28)) ? ($signed({1'b0, hm_j}) - 32'(TWO_PI_Q28))
                                           : $signed({1'b0, hm_j});

    assign chord_next = sj.straight ? CHORD_W'(sj.sp) : CHORD_W'(quo);

    always_comb
    begin
        tail_next.px      = sj.px;
        tail_next.py      = sj.py;
        tail_next.nx      = sj.nx;
        tail_next.ny      = sj.ny;
        tail_next.heading = sj.inrange ? sj.h_in : hwrap[30:0];
        tail_next.s       = sj.s;
        tail_next.e       = sj.e;
        tail_next.c       = sj.c;
    end

    logic signed [CHORD_W-1:0]  chord_reg;
    logic signed [CORDIC_W-1:0] co_reg, si_reg;
    tail_t                      tj1_reg, tj2_reg, tj3_reg;

    // Displacement: floor(chord * trig / 2^30) with the chord split at bit 16
    logic signed [31:0] ah;
    logic signed [16:0] al;
    logic signed [65:0] phx_reg, phy_reg;
    logic signed [50:0] plx_reg, ply_reg;
    logic signed [66:0] tx_reg, ty_reg;
    logic signed [66:0] tx_next, ty_next;

    assign ah = chord_reg[CHORD_W-1:16];
    assign al = $signed({1'b0, chord_reg[15:0]});

    assign tx_next = 67'(phx_reg) + 67'(plx_reg >>> 16);
    assign ty_next = 67'(phy_reg) + 67'(ply_reg >>> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chord_reg <= chord_next;
            co_reg    <= co_dly[DIV_LAT-1];
            si_reg    <= si_dly[DIV_LAT-1];
            tj1_reg   <= tail_next;
            phx_reg   <= ah * co_reg;
            phy_reg   <= ah * si_reg;
            plx_reg   <= al * co_reg;
            ply_reg   <= al * si_reg;
            tj2_reg   <= tj1_reg;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            tj3_reg   <= tj2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add displacement and noise, saturate positions
    logic signed [52:0] dx, dy;
    logic signed [54:0] sx, sy;
    logic signed [31:0] x_next, y_next;

    assign dx = tx_reg[66:14];
    assign dy = ty_reg[66:14];
    assign sx = 55'(tj3_reg.px) + 55'(dx) + 55'(tj3_reg.nx);
    assign sy = 55'(tj3_reg.py) + 55'(dy) + 55'(tj3_reg.ny);

    always_comb
    begin
        priority if (sx > 55'sh7FFF_FFFF)
            x_next = 32'sh7FFF_FFFF;
        else if (sx < -55'sh8000_0000)
            x_next = 32'sh8000_0000;
        else
            x_next = sx[31:0];

        priority if (sy > 55'sh7FFF_FFFF)
            y_next = 32'sh7FFF_FFFF;
        else if (sy < -55'sh8000_0000)
            y_next = 32'sh8000_0000;
        else
            y_next = sy[31:0];
    end

    logic signed [31:0] next_x_reg, next_y_reg, next_speed_reg, next_curvature_reg;
    logic signed [30:0] next_heading_reg;
    logic        [30:0] next_extent_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            next_x_reg         <= x_next;
            next_y_reg         <= y_next;
            next_heading_reg   <= tj3_reg.heading;
            next_speed_reg     <= tj3_reg.s;
            next_extent_reg    <= tj3_reg.e;
            next_curvature_reg <= tj3_reg.c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_x         = next_x_reg;
    assign next_y         = next_y_reg;
    assign next_heading   = next_heading_reg;
    assign next_speed     = next_speed_reg;
    assign next_extent    = next_extent_reg;
    assign next_curvature = next_curvature_reg;

endmodule

### src/trmp_mod2pi.sv
// Pipelined floor modulo 2pi of a signed Q.28 angle, one compare/subtract per stage.
module trmp_mod2pi
    import trmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [MOD_W-1:0] ang,
    output logic        [ANG_W-1:0] res
);

    logic [MOD_W-1:0] u_reg    [MOD_STEPS+1];
    logic             neg_reg  [MOD_STEPS+1];
    logic [MOD_W-1:0] u_next   [MOD_STEPS];
    logic [ANG_W-1:0] res_reg;
    logic [ANG_W-1:0] res_next;
    logic [ANG_W-1:0] m;

    // Subtract 2pi scaled down by one power of two per stage
    always_comb
    begin
        logic [MOD_W-1:0] sub;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            sub = MOD_W'(TWO_PI_Q28) << (MOD_STEPS - 1 - i);
            u_next[i] = (u_reg[i] >= sub) ? (u_reg[i] - sub) : u_reg[i];
        end
    end

    // Negative inputs are reduced as their complement and mirrored back
    assign m        = u_reg[MOD_STEPS][ANG_W-1:0];
    assign res_next = neg_reg[MOD_STEPS] ? (ANG_W'(TWO_PI_Q28 - 1) - m) : m;

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0]   <= ang[MOD_W-1] ? ~ang : ang;
            neg_reg[0] <= ang[MOD_W-1];
            for (int i = 0; i < MOD_STEPS; i++)
            begin
                u_reg[i+1]   <= u_next[i];
                neg_reg[i+1] <= neg_reg[i];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### src/trmp_sincos.sv
// Pipelined cosine and sine of a Q.28 angle: modulo 2pi, quadrant fold, rotation stages.
module trmp_sincos
    import trmp_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [MOD_W-1:0]    ang,
    output logic signed [CORDIC_W-1:0] cosv,
    output logic signed [CORDIC_W-1:0] sinv
);

    logic        [ANG_W-1:0]    r;
    logic signed [32:0]         rs;
    logic signed [32:0]         rf;
    logic                       fneg;
    logic signed [CORDIC_W-1:0] x_reg   [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0] y_reg   [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0] z_reg   [CORDIC_STAGES+1];
    logic                       neg_reg [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0] x_next  [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] y_next  [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] z_next  [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] cos_reg;
    logic signed [CORDIC_W-1:0] sin_reg;

    trmp_mod2pi u_mod
    (
        .clk (clk),
        .en  (en),
        .ang (ang),
        .res (r)
    );

    // Move into [-pi, pi] and fold onto [-pi/2, pi/2]
    always_comb
    begin
        rs = (r > ANG_W'(PI_Q28)) ? ($signed({2'b00, r}) - 33'(TWO_PI_Q28))
                                  : $signed({2'b00, r});
        fneg = 1'b0;
        rf   = rs;
        if (rs > 33'(HALF_PI_Q28))
        begin
            rf   = rs - 33'(PI_Q28);
            fneg = 1'b1;
        end
        else if (rs < -33'(HALF_PI_Q28))
        begin
            rf   = rs + 33'(PI_Q28);
            fneg = 1'b1;
        end
    end

    // One micro-rotation per stage
    always_comb
    begin
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic signed [CORDIC_W-1:0] at;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            at = CORDIC_W'(atan_q30(i));
            if (!z_reg[i][CORDIC_W-1])
            begin
                x_next[i] = x_reg[i] - ys;
                y_next[i] = y_reg[i] + xs;
                z_next[i] = z_reg[i] - at;
            end
            else
            begin
                x_next[i] = x_reg[i] + ys;
                y_next[i] = y_reg[i] - xs;
                z_next[i] = z_reg[i] + at;
            end
        end
    end

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_W'(CORDIC_GAIN_Q30);
            y_reg[0]   <= '0;
            z_reg[0]   <= CORDIC_W'(rf) <<< 2;
            neg_reg[0] <= fneg;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                x_reg[i+1]   <= x_next[i];
                y_reg[i+1]   <= y_next[i];
                z_reg[i+1]   <= z_next[i];
                neg_reg[i+1] <= neg_reg[i];
            end
            cos_reg <= neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
            sin_reg <= neg_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        end
    end

    assign cosv = cos_reg;
    assign sinv = sin_reg;

endmodule

### src/trmp_div.sv
// Pipelined signed divide of sine * 2^17 by curvature, one quotient bit per stage.
module trmp_div
    import trmp_pkg::*;
#(
    parameter int DIVIDER_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [CORDIC_W-1:0]    num_sin,
    input  logic signed [DEN_W-1:0]       den,
    output logic signed [DIVIDER_BITS-1:0] quo
);

    localparam logic [DIV_NW-1:0] DLIM = (DIV_NW'(1) << (DIVIDER_BITS - 1)) - DIV_NW'(1);

    logic [DIV_NW-1:0]       w_reg    [DIV_NW+1];
    logic [DEN_W-1:0]        rem_reg  [DIV_NW+1];
    logic [DEN_W-1:0]        d_reg    [DIV_NW+1];
    logic                    sg_reg   [DIV_NW+1];
    logic [DIV_NW-1:0]       w_next   [DIV_NW];
    logic [DEN_W-1:0]        rem_next [DIV_NW];
    logic [CORDIC_W-1:0]     n_mag;
    logic [DEN_W-1:0]        d_mag;
    logic [DIV_NW-1:0]       q_sat;
    logic [DIVIDER_BITS-1:0] q_mag;
    logic signed [DIVIDER_BITS-1:0] quo_reg;

    // Operand magnitudes
    assign n_mag = num_sin[CORDIC_W-1] ? CORDIC_W'(-num_sin) : CORDIC_W'(num_sin);
    assign d_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // Restoring step: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           ge;
        for (int i = 0; i < DIV_NW; i++)
        begin
            trial       = {rem_reg[i], w_reg[i][DIV_NW-1]};
            ge          = (trial >= {1'b0, d_reg[i]});
            rem_next[i] = ge ? DEN_W'(trial - {1'b0, d_reg[i]}) : trial[DEN_W-1:0];
            w_next[i]   = {w_reg[i][DIV_NW-2:0], ge};
        end
    end

    // Saturate the magnitude, then apply the sign (truncation toward zero)
    assign q_sat = (w_reg[DIV_NW] > DLIM) ? DLIM : w_reg[DIV_NW];
    assign q_mag = q_sat[DIVIDER_BITS-1:0];

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0]   <= {n_mag, 17'd0};
            rem_reg[0] <= '0;
            d_reg[0]   <= d_mag;
            sg_reg[0]  <= num_sin[CORDIC_W-1] ^ den[DEN_W-1];
            for (int i = 0; i < DIV_NW; i++)
            begin
                w_reg[i+1]   <= w_next[i];
                rem_reg[i+1] <= rem_next[i];
                d_reg[i+1]   <= d_reg[i];
                sg_reg[i+1]  <= sg_reg[i];
            end
            quo_reg <= sg_reg[DIV_NW] ? $signed(-q_mag) : $signed(q_mag);
        end
    end

    assign quo = quo_reg;

endmodule

### src/trmp_chk.sv
// Port-level checks for the motion predictor, bound to the top level.
module trmp_chk
    import trmp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] next_x,
    input logic signed [30:0] next_heading,
    input logic signed [31:0] next_speed
);

    localparam logic signed [30:0] PI_H = 31'(PI_Q28);

    // The input only stalls when a finished result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output side is free");

    // A held result keeps its payload (x and speed are checked)
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(next_x) && $stable(next_speed)))
        else $error("stalled result changed");

    // Predicted heading is always wrapped into [-pi, pi]
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((next_heading >= -PI_H) && (next_heading <= PI_H)))
        else $error("heading outside [-pi, pi]");

endmodule

bind turn_rate_motion_predict_unit trmp_chk u_trmp_chk (.*);
